[hdl/osl_pkg.sv]
// shared types, constants and codes of the obstacle speed limiter
package osl_pkg;

    // point coordinate width and fixed field widths
    localparam int OSL_COORD_BITS = 16;
    localparam int OSL_CMD_W      = 16;
    localparam int OSL_CMD_N      = 6;
    localparam int OSL_CFG_W      = 15;
    localparam int OSL_CFG_IDX_W  = 4;

    // stream packing, padded to whole bytes
    localparam int OSL_IN_BITS = 2 * OSL_COORD_BITS + OSL_CMD_N * OSL_CMD_W;
    localparam int OSL_IN_W    = ((OSL_IN_BITS + 7) / 8) * 8;
    localparam int OSL_OUT_W   = OSL_CMD_N * OSL_CMD_W;

    // shared multiplier and squared distance widths
    localparam int OSL_MUL_W  = (OSL_COORD_BITS > OSL_CMD_W) ? OSL_COORD_BITS : OSL_CMD_W;
    localparam int OSL_PROD_W = 2 * OSL_MUL_W;
    localparam int OSL_SQ_W   = OSL_PROD_W + 1;

    // nearest squared distance, all ones when no point was kept
    localparam int                    OSL_NEAR_W    = 31;
    localparam logic [OSL_NEAR_W-1:0] OSL_NEAR_NONE = '1;
    // 50 mm minimum range, squared
    localparam int                    OSL_MIN_KEEP_SQ = 2500;

    // square root and division sequencing
    localparam int OSL_ROOT_W     = 16;
    localparam int OSL_VAL_W      = 2 * OSL_ROOT_W;
    localparam int OSL_REM_W      = OSL_ROOT_W + 1;
    localparam int OSL_SQRT_STEPS = OSL_ROOT_W;
    localparam int OSL_QUO_W      = 2 * OSL_CFG_W;
    localparam int OSL_DIV_STEPS  = OSL_QUO_W;
    localparam int OSL_CNT_W      = $clog2(OSL_DIV_STEPS);
    localparam int OSL_ALU_W      = OSL_REM_W + 3;

    // register reset values
    localparam logic [OSL_CFG_W-1:0] OSL_RADIUS_RST = 15'd1000;
    localparam logic [OSL_CFG_W-1:0] OSL_SIDE_RST   = 15'd1000;
    localparam logic [OSL_CFG_W-1:0] OSL_STOP_RST   = 15'd500;
    localparam logic [OSL_CFG_W-1:0] OSL_SLOW_RST   = 15'd1000;

    typedef enum logic [OSL_CFG_IDX_W-1:0] {
        OSL_REG_RADIUS = 4'd0,
        OSL_REG_SIDE   = 4'd1,
        OSL_REG_STOP   = 4'd2,
        OSL_REG_SLOW   = 4'd3
    } t_osl_reg;

    typedef enum logic [1:0] {
        OSL_KIND_CMD   = 2'd0,
        OSL_KIND_POINT = 2'd1,
        OSL_KIND_END   = 2'd2
    } t_osl_kind;

    typedef enum logic [1:0] {
        OSL_ACT_CONTINUE = 2'd0,
        OSL_ACT_SLOW     = 2'd1,
        OSL_ACT_STOP     = 2'd2
    } t_osl_act;

    typedef enum logic [3:0] {
        OSL_ST_IDLE,
        OSL_ST_SQX,
        OSL_ST_SQY,
        OSL_ST_SQR,
        OSL_ST_CMP,
        OSL_ST_SQRT,
        OSL_ST_DECIDE,
        OSL_ST_MUL,
        OSL_ST_MULW,
        OSL_ST_DIV,
        OSL_ST_OUT
    } t_osl_state;

    typedef enum logic [1:0] {
        OSL_MUL_SQX,
        OSL_MUL_SQY,
        OSL_MUL_SQR,
        OSL_MUL_SCALE
    } t_osl_mul_sel;

    // sequencer to datapath
    typedef struct packed {
        logic         in_ready;
        t_osl_mul_sel mul_sel;
        logic         acc_load;
        logic         acc_add;
        logic         filt_upd;
        logic         sqrt_step;
        logic         decide;
        logic         div_init;
        logic         div_step;
        logic         out_load;
    } t_osl_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic      in_acc;
        t_osl_kind kind;
        logic      near_none;
        logic      scale_go;
        logic      out_free;
    } t_osl_stat;

endpackage

[hdl/osl_mul.sv]
// shared unsigned multiplier with registered product
module osl_mul (
    input  logic                           i_clk,
    input  logic [osl_pkg::OSL_MUL_W-1:0]  i_a,
    input  logic [osl_pkg::OSL_MUL_W-1:0]  i_b,
    output logic [osl_pkg::OSL_PROD_W-1:0] o_p
);
    import osl_pkg::*;

    logic [OSL_PROD_W-1:0] r_p;

    // one product per cycle, ready the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_p <= OSL_PROD_W'(i_a) * OSL_PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

[hdl/osl_seq.sv]
// sequencer stepping the shared multiplier and subtractor through each request
module osl_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  osl_pkg::t_osl_stat i_stat,
    output osl_pkg::t_osl_ctrl o_ctrl
);
    import osl_pkg::*;

    t_osl_state           r_state, n_state;
    logic [OSL_CNT_W-1:0] r_cnt, n_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OSL_ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // step counter for the root and divide loops
    always_comb begin
        n_cnt = r_cnt;
        if (r_state == OSL_ST_IDLE && i_stat.in_acc) begin
            n_cnt = OSL_CNT_W'(OSL_SQRT_STEPS - 1);
        end else if (r_state == OSL_ST_MULW) begin
            n_cnt = OSL_CNT_W'(OSL_DIV_STEPS - 1);
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            OSL_ST_IDLE: begin
                if (i_stat.in_acc) begin
                    if (i_stat.kind == OSL_KIND_POINT) begin
                        n_state = OSL_ST_SQX;
                    end else if (i_stat.kind == OSL_KIND_END) begin
                        n_state = i_stat.near_none ? OSL_ST_OUT : OSL_ST_SQRT;
                    end
                end
            end
            OSL_ST_SQX:    n_state = OSL_ST_SQY;
            OSL_ST_SQY:    n_state = OSL_ST_SQR;
            OSL_ST_SQR:    n_state = OSL_ST_CMP;
            OSL_ST_CMP:    n_state = OSL_ST_IDLE;
            OSL_ST_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = OSL_ST_DECIDE;
                end
            end
            OSL_ST_DECIDE: n_state = i_stat.scale_go ? OSL_ST_MUL : OSL_ST_OUT;
            OSL_ST_MUL:    n_state = OSL_ST_MULW;
            OSL_ST_MULW:   n_state = OSL_ST_DIV;
            OSL_ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = OSL_ST_OUT;
                end
            end
            OSL_ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = OSL_ST_IDLE;
                end
            end
            default:       n_state = OSL_ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        o_ctrl           = '0;
        o_ctrl.mul_sel   = OSL_MUL_SCALE;
        o_ctrl.in_ready  = (r_state == OSL_ST_IDLE);
        o_ctrl.acc_load  = (r_state == OSL_ST_SQY);
        o_ctrl.acc_add   = (r_state == OSL_ST_SQR);
        o_ctrl.filt_upd  = (r_state == OSL_ST_CMP);
        o_ctrl.sqrt_step = (r_state == OSL_ST_SQRT);
        o_ctrl.decide    = (r_state == OSL_ST_DECIDE);
        o_ctrl.div_init  = (r_state == OSL_ST_MULW);
        o_ctrl.div_step  = (r_state == OSL_ST_DIV);
        o_ctrl.out_load  = (r_state == OSL_ST_OUT) && i_stat.out_free;
        unique case (r_state)
            OSL_ST_SQX: o_ctrl.mul_sel = OSL_MUL_SQX;
            OSL_ST_SQY: o_ctrl.mul_sel = OSL_MUL_SQY;
            OSL_ST_SQR: o_ctrl.mul_sel = OSL_MUL_SQR;
            default:    o_ctrl.mul_sel = OSL_MUL_SCALE;
        endcase
    end

endmodule

[hdl/obstacle_speed_limiter_core.sv]
// top level of the obstacle speed limiter: stream ports, datapath and register file
//
// The block holds the latest six-component velocity request (tuser 0) and takes
// cloud points (tuser 1) and end-of-cloud markers (tuser 2) on the slave stream.
// Points inside the window (planar range 50 mm to radius, |y| within the side
// limit, x not negative) update the least squared distance; at the end marker its
// floor square root sets the action and the limited forward speed, which leave on
// the master stream as one result; tuser 3 is dropped. Everything runs on one
// registered 16x16 multiplier and one 20-bit subtractor, one item at a time:
// a velocity request is only stored, a point takes three squares through the
// multiplier, then the window compare, and an end marker goes straight to the
// result for an empty cloud, else through the 16-step square root and, when the
// speed is scaled, one product and a 30-step restoring divide. An end marker also
// waits while a previous result is still held on the master side. Configuration
// writes are taken every cycle and must only arrive while the block is idle.
module obstacle_speed_limiter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // point_x, point_y, cmd_linear_x, cmd_linear_y, cmd_linear_z,
    // cmd_angular_x, cmd_angular_y, cmd_angular_z
    input  logic [osl_pkg::OSL_IN_W-1:0]     s_axis_tdata,
    input  logic [1:0]                       s_axis_tuser,  // kind
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // out_linear_x, out_linear_y, out_linear_z, out_angular_x,
    // out_angular_y, out_angular_z
    output logic [osl_pkg::OSL_OUT_W-1:0]    m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,  // action
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [osl_pkg::OSL_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [osl_pkg::OSL_CFG_W-1:0]    i_cfg_data
);
    import osl_pkg::*;

    t_osl_ctrl w_ctrl;
    t_osl_stat w_stat;

    // configuration registers
    logic [OSL_CFG_W-1:0] r_radius, r_side, r_stop, r_slow;

    // held velocity request and nearest distance
    logic [OSL_CMD_W-1:0]  r_cmd [OSL_CMD_N];
    logic [OSL_NEAR_W-1:0] r_near;

    // point work registers
    logic [OSL_MUL_W-1:0] r_ax, r_ay;
    logic                 r_xneg;
    logic [OSL_SQ_W-1:0]  r_acc;

    // end-of-cloud work registers
    logic [OSL_VAL_W-1:0]  r_val;
    logic [OSL_REM_W-1:0]  r_rem;
    logic [OSL_ROOT_W-1:0] r_root;
    logic [OSL_CMD_W-1:0]  r_lx;
    t_osl_act              r_act;
    logic                  r_scaled;
    logic [OSL_CFG_W-1:0]  r_diff, r_den, r_drem;
    logic [OSL_QUO_W-1:0]  r_quo;

    // output register
    logic                 r_m_valid;
    logic [OSL_OUT_W-1:0] r_m_data;
    t_osl_act             r_m_user;

    logic                      w_in_acc;
    logic [OSL_COORD_BITS-1:0] w_px, w_py, w_abx, w_aby;
    logic [OSL_MUL_W-1:0]      w_mul_a, w_mul_b;
    logic [OSL_PROD_W-1:0]     w_prod;
    logic [OSL_ALU_W-1:0]      w_alu_a, w_alu_b;
    logic [OSL_ALU_W:0]        w_alu_d;
    logic                      w_alu_ge;
    logic [OSL_REM_W+1:0]      w_rem_sh;
    logic [OSL_ROOT_W+1:0]     w_trial;
    logic [OSL_CFG_W:0]        w_drem_sh;
    logic                      w_keep;
    logic                      w_lt_stop, w_in_band, w_lx_pos;
    logic [OSL_CMD_W-1:0]      w_out_lx;

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = w_ctrl.in_ready;
    assign o_cfg_ready   = 1'b1;

    // point coordinates and magnitudes
    assign w_px  = s_axis_tdata[OSL_COORD_BITS-1:0];
    assign w_py  = s_axis_tdata[2*OSL_COORD_BITS-1:OSL_COORD_BITS];
    assign w_abx = w_px[OSL_COORD_BITS-1] ? (~w_px + 1'b1) : w_px;
    assign w_aby = w_py[OSL_COORD_BITS-1] ? (~w_py + 1'b1) : w_py;

    // sequencer status
    assign w_stat.in_acc    = w_in_acc;
    assign w_stat.kind      = t_osl_kind'(s_axis_tuser);
    assign w_stat.near_none = (r_near == OSL_NEAR_NONE);
    assign w_stat.scale_go  = !w_lt_stop && w_in_band && w_lx_pos;
    assign w_stat.out_free  = !r_m_valid || m_axis_tready;

    osl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // multiplier operand select
    always_comb begin
        unique case (w_ctrl.mul_sel)
            OSL_MUL_SQX: begin
                w_mul_a = r_ax;
                w_mul_b = r_ax;
            end
            OSL_MUL_SQY: begin
                w_mul_a = r_ay;
                w_mul_b = r_ay;
            end
            OSL_MUL_SQR: begin
                w_mul_a = OSL_MUL_W'(r_radius);
                w_mul_b = OSL_MUL_W'(r_radius);
            end
            default: begin
                w_mul_a = OSL_MUL_W'(r_diff);
                w_mul_b = OSL_MUL_W'(r_lx[OSL_CMD_W-2:0]);
            end
        endcase
    end

    osl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // shared subtractor for the root and divide steps
    assign w_rem_sh  = {r_rem, r_val[OSL_VAL_W-1 -: 2]};
    assign w_trial   = {r_root, 2'b01};
    assign w_drem_sh = {r_drem, r_quo[OSL_QUO_W-1]};
    assign w_alu_a   = w_ctrl.sqrt_step ? OSL_ALU_W'(w_rem_sh) : OSL_ALU_W'(w_drem_sh);
    assign w_alu_b   = w_ctrl.sqrt_step ? OSL_ALU_W'(w_trial) : OSL_ALU_W'(r_den);
    assign w_alu_d   = {1'b0, w_alu_a} - {1'b0, w_alu_b};
    assign w_alu_ge  = !w_alu_d[OSL_ALU_W];

    // window test on the accumulated squared distance
    assign w_keep = (r_acc >= OSL_SQ_W'(OSL_MIN_KEEP_SQ)) &&
                    (r_acc <= OSL_SQ_W'(w_prod)) &&
                    (r_ay <= OSL_MUL_W'(r_side)) && !r_xneg &&
                    (r_acc < OSL_SQ_W'(r_near));

    // decision on the nearest distance
    assign w_lt_stop = r_root < OSL_ROOT_W'(r_stop);
    assign w_in_band = (r_root > OSL_ROOT_W'(r_stop)) && (r_root < OSL_ROOT_W'(r_slow));
    assign w_lx_pos  = !r_lx[OSL_CMD_W-1] && (r_lx != '0);
    assign w_out_lx  = r_scaled ? r_quo[OSL_CMD_W-1:0] : r_lx;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= OSL_RADIUS_RST;
            r_side   <= OSL_SIDE_RST;
            r_stop   <= OSL_STOP_RST;
            r_slow   <= OSL_SLOW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_osl_reg'(i_cfg_index))
                OSL_REG_RADIUS: r_radius <= i_cfg_data;
                OSL_REG_SIDE:   r_side   <= i_cfg_data;
                OSL_REG_STOP:   r_stop   <= i_cfg_data;
                OSL_REG_SLOW:   r_slow   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // held velocity request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < OSL_CMD_N; i++) begin
                r_cmd[i] <= '0;
            end
        end else if (w_in_acc && t_osl_kind'(s_axis_tuser) == OSL_KIND_CMD) begin
            for (int i = 0; i < OSL_CMD_N; i++) begin
                r_cmd[i] <= s_axis_tdata[2*OSL_COORD_BITS + i*OSL_CMD_W +: OSL_CMD_W];
            end
        end
    end

    // nearest squared distance, cleared after each cloud
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= OSL_NEAR_NONE;
        end else if (w_ctrl.out_load) begin
            r_near <= OSL_NEAR_NONE;
        end else if (w_ctrl.filt_upd && w_keep) begin
            r_near <= r_acc[OSL_NEAR_W-1:0];
        end
    end

    // point capture and squared distance accumulation
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ax   <= OSL_MUL_W'(w_abx);
            r_ay   <= OSL_MUL_W'(w_aby);
            r_xneg <= w_px[OSL_COORD_BITS-1];
        end
        if (w_ctrl.acc_load) begin
            r_acc <= OSL_SQ_W'(w_prod);
        end else if (w_ctrl.acc_add) begin
            r_acc <= r_acc + OSL_SQ_W'(w_prod);
        end
    end

    // square root, decision and scaling divide
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_val    <= OSL_VAL_W'(r_near);
            r_rem    <= '0;
            r_root   <= '0;
            r_lx     <= r_cmd[0];
            r_act    <= OSL_ACT_CONTINUE;
            r_scaled <= 1'b0;
        end else if (w_ctrl.sqrt_step) begin
            r_val  <= {r_val[OSL_VAL_W-3:0], 2'b00};
            r_root <= {r_root[OSL_ROOT_W-2:0], w_alu_ge};
            r_rem  <= w_alu_ge ? w_alu_d[OSL_REM_W-1:0] : w_rem_sh[OSL_REM_W-1:0];
        end else if (w_ctrl.decide) begin
            r_diff   <= OSL_CFG_W'(r_root - OSL_ROOT_W'(r_stop));
            r_den    <= r_slow - r_stop;
            r_scaled <= w_stat.scale_go;
            if (w_lt_stop) begin
                r_act <= OSL_ACT_STOP;
                if (w_lx_pos) begin
                    r_lx <= '0;
                end
            end else if (w_in_band) begin
                r_act <= OSL_ACT_SLOW;
            end
        end else if (w_ctrl.div_init) begin
            r_quo  <= w_prod[OSL_QUO_W-1:0];
            r_drem <= '0;
        end else if (w_ctrl.div_step) begin
            r_quo  <= {r_quo[OSL_QUO_W-2:0], w_alu_ge};
            r_drem <= w_alu_ge ? w_alu_d[OSL_CFG_W-1:0] : w_drem_sh[OSL_CFG_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_load) begin
            r_m_data <= {r_cmd[5], r_cmd[4], r_cmd[3], r_cmd[2], r_cmd[1], w_out_lx};
            r_m_user <= r_act;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

[hdl/osl_chk.sv]
// port-level checks of the obstacle speed limiter and their binding
module osl_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic [osl_pkg::OSL_IN_W-1:0]     s_axis_tdata,
    input logic [1:0]                       s_axis_tuser,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [osl_pkg::OSL_OUT_W-1:0]    m_axis_tdata,
    input logic [1:0]                       m_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [osl_pkg::OSL_CFG_IDX_W-1:0] i_cfg_index,
    input logic [osl_pkg::OSL_CFG_W-1:0]    i_cfg_data
);
    import osl_pkg::*;

    // a point keeps the block busy for its squaring steps
    a_point_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OSL_KIND_POINT)
            |=> !s_axis_tready)
        else $error("input ready right after a point request");

    // an end marker keeps the block busy until its result is loaded
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OSL_KIND_END)
            |=> !s_axis_tready)
        else $error("input ready right after an end marker");

    // a new result only appears out of a busy phase
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while input side was idle");

    // stop never leaves a positive forward speed
    a_stop_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == OSL_ACT_STOP)
            |-> (m_axis_tdata[15] || m_axis_tdata[15:0] == 16'd0))
        else $error("positive forward speed with stop action");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind obstacle_speed_limiter_core osl_chk u_osl_chk (.*);

[dv/osl_speed_checker.sv]
// checker of the obstacle speed limiter: watches every channel, predicts and compares results
`timescale 1ns / 100ps

module osl_speed_checker
    import osl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // point_x, point_y, cmd_linear_x .. cmd_angular_z
    input  logic [OSL_IN_W-1:0]      i_s_tdata,
    input  logic [1:0]               i_s_tuser,  // kind
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    // out_linear_x .. out_angular_z
    input  logic [OSL_OUT_W-1:0]     i_m_tdata,
    input  logic [1:0]               i_m_tuser,  // action
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [OSL_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [OSL_CFG_W-1:0]     i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_results,
    output int                       o_slowed,
    output int                       o_stopped
);

    typedef struct packed {
        logic [OSL_OUT_W-1:0] data;
        t_osl_act             act;
    } t_limited_cmd;

    // shadow registers and block state
    logic [OSL_CFG_W-1:0]  radius_mm;
    logic [OSL_CFG_W-1:0]  side_mm;
    logic [OSL_CFG_W-1:0]  stop_mm;
    logic [OSL_CFG_W-1:0]  slow_mm;
    logic [OSL_OUT_W-1:0]  desired_cmd;
    logic [OSL_NEAR_W-1:0] nearest_sq;

    // limited commands still owed by the block, oldest first
    t_limited_cmd limited_cmd_q[$];

    string field_name [OSL_CMD_N] = '{"out_linear_x", "out_linear_y", "out_linear_z",
                                      "out_angular_x", "out_angular_y", "out_angular_z"};

    // floor square root, one result bit per step from the top
    function automatic logic [15:0] floor_root(input logic [OSL_NEAR_W-1:0] v);
        logic [15:0] r;
        logic [15:0] t;
        logic [31:0] sq;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            t  = r | (16'd1 << b);
            sq = 32'(t) * 32'(t);
            if (sq <= 32'(v))
                r = t;
        end
        return r;
    endfunction

    // window filter and nearest distance update for one point
    function automatic void track_point(input logic [15:0] px, input logic [15:0] py);
        logic signed [16:0] sx;
        logic signed [16:0] sy;
        logic [16:0]        ax;
        logic [16:0]        ay;
        logic [33:0]        d2;
        logic [33:0]        r2;
        sx = signed'(px);
        sy = signed'(py);
        ax = sx[16] ? 17'(-sx) : 17'(sx);
        ay = sy[16] ? 17'(-sy) : 17'(sy);
        d2 = 34'(ax) * 34'(ax) + 34'(ay) * 34'(ay);
        r2 = 34'(radius_mm) * 34'(radius_mm);
        if (d2 >= 34'(OSL_MIN_KEEP_SQ) && d2 <= r2 && ay <= 17'(side_mm) && !px[15] &&
            d2 < 34'(nearest_sq))
            nearest_sq = d2[OSL_NEAR_W-1:0];
    endfunction

    // action and forward speed from the nearest kept point
    function automatic t_limited_cmd limit_command();
        t_limited_cmd       res;
        logic signed [15:0] lx;
        logic [15:0]        m;
        logic [63:0]        scaled;
        lx      = desired_cmd[OSL_CMD_W-1:0];
        res.act = OSL_ACT_CONTINUE;
        if (nearest_sq != OSL_NEAR_NONE) begin
            m = floor_root(nearest_sq);
            if (m < 16'(stop_mm)) begin
                res.act = OSL_ACT_STOP;
                if (lx > 0)
                    lx = '0;
            end else if (m > 16'(stop_mm) && m < 16'(slow_mm)) begin
                res.act = OSL_ACT_SLOW;
                if (lx > 0) begin
                    scaled = (64'(m) - 64'(stop_mm)) * 64'(lx);
                    lx     = 16'(scaled / (64'(slow_mm) - 64'(stop_mm)));
                end
            end
        end
        res.data = {desired_cmd[OSL_OUT_W-1:OSL_CMD_W], lx};
        return res;
    endfunction

    // follow requests on all channels and compare every result
    always @(posedge i_clk) begin : watch
        t_limited_cmd       want;
        logic signed [15:0] want_f;
        logic signed [15:0] got_f;
        int                 bad;
        int                 added;
        int                 taken;
        bad   = 0;
        added = 0;
        taken = 0;
        if (!i_rst_n) begin
            radius_mm   = OSL_RADIUS_RST;
            side_mm     = OSL_SIDE_RST;
            stop_mm     = OSL_STOP_RST;
            slow_mm     = OSL_SLOW_RST;
            desired_cmd = '0;
            nearest_sq  = OSL_NEAR_NONE;
            limited_cmd_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
            o_results    <= 0;
            o_slowed     <= 0;
            o_stopped    <= 0;
        end else begin
            // register write request
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    OSL_REG_RADIUS: radius_mm = i_cfg_data;
                    OSL_REG_SIDE:   side_mm   = i_cfg_data;
                    OSL_REG_STOP:   stop_mm   = i_cfg_data;
                    OSL_REG_SLOW:   slow_mm   = i_cfg_data;
                    default: ;
                endcase
            end

            // input request
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    OSL_KIND_CMD: begin
                        desired_cmd = i_s_tdata[2*OSL_COORD_BITS +: OSL_OUT_W];
                    end
                    OSL_KIND_POINT: begin
                        track_point(i_s_tdata[0 +: OSL_COORD_BITS],
                                    i_s_tdata[OSL_COORD_BITS +: OSL_COORD_BITS]);
                    end
                    OSL_KIND_END: begin
                        limited_cmd_q.insert(limited_cmd_q.size(), limit_command());
                        nearest_sq = OSL_NEAR_NONE;
                        added      = 1;
                    end
                    default: ;
                endcase
            end

            // result request
            if (i_m_tvalid && i_m_tready) begin
                if (limited_cmd_q.size() == 0) begin
                    $error("result with no end of cloud waiting: action %0d data %h",
                           i_m_tuser, i_m_tdata);
                    bad++;
                end else begin
                    want  = limited_cmd_q.pop_front();
                    taken = 1;
                    for (int f = 0; f < OSL_CMD_N; f++) begin
                        want_f = want.data[f*OSL_CMD_W +: OSL_CMD_W];
                        got_f  = i_m_tdata[f*OSL_CMD_W +: OSL_CMD_W];
                        if (got_f !== want_f) begin
                            $error("%s: expected %0d, got %0d", field_name[f], want_f, got_f);
                            bad++;
                        end
                    end
                    if (i_m_tuser !== want.act) begin
                        $error("action: expected %0d, got %0d", want.act, i_m_tuser);
                        bad++;
                    end
                    if (want.act == OSL_ACT_SLOW)
                        o_slowed <= o_slowed + 1;
                    if (want.act == OSL_ACT_STOP)
                        o_stopped <= o_stopped + 1;
                end
            end

            o_fail_count <= o_fail_count + bad;
            o_pending    <= o_pending + added - taken;
            o_results    <= o_results + taken;
        end
    end

endmodule

[dv/tb_obstacle_speed_limiter_core.sv]
// testbench top of the obstacle speed limiter: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_obstacle_speed_limiter_core;
    import osl_pkg::*;

    // cycles to let an in-flight item finish before a register write
    localparam int         SETTLE_CYCLES = 80;
    localparam int         PHASE_ITEMS   = 300;
    localparam int         N_PHASES      = 6;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic [OSL_IN_W-1:0]      s_axis_tdata  = '0;
    logic [1:0]               s_axis_tuser  = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [OSL_OUT_W-1:0]     m_axis_tdata;
    logic [1:0]               m_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [OSL_CFG_IDX_W-1:0] cfg_index     = '0;
    logic [OSL_CFG_W-1:0]     cfg_data      = '0;

    int fail_count;
    int pending;
    int results;
    int slowed;
    int stopped;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int items_sent    = 0;
    int settings_run  = 0;
    int cur_radius    = OSL_RADIUS_RST;
    int cur_side      = OSL_SIDE_RST;
    int cur_stop      = OSL_STOP_RST;
    int cur_slow      = OSL_SLOW_RST;

    // radius, side limit, stop, slow per random phase
    int phase_cfg [N_PHASES][4] = '{
        '{32767, 32767, 0, 32767},
        '{0, 0, 0, 0},
        '{2000, 300, 800, 1500},
        '{32767, 32767, 32767, 32767},
        '{1500, 1500, 1200, 400},
        '{1000, 1000, 100, 1000}
    };

    obstacle_speed_limiter_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    osl_speed_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_slowed     (slowed),
        .o_stopped    (stopped)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // receiver stalls
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // run limit
    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [127:0] random_bits();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // random desired command, forward speed positive about three quarters of the time
    function automatic logic [OSL_OUT_W-1:0] random_cmd();
        logic [OSL_OUT_W-1:0] cmd;
        cmd = {$urandom, $urandom, $urandom};
        if ($urandom_range(1) == 0)
            cmd[OSL_CMD_W-1] = 1'b0;
        return cmd;
    endfunction

    // one request on the slave stream; valid stays up for a back-to-back next item
    task automatic push_item(input logic [1:0] kind, input logic [OSL_IN_W-1:0] data);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic push_point(input int x, input int y);
        logic [127:0] fill;
        fill = random_bits();
        push_item(OSL_KIND_POINT, {fill[127:32], 16'(y), 16'(x)});
    endtask

    task automatic push_cmd(input logic [OSL_OUT_W-1:0] cmd);
        push_item(OSL_KIND_CMD, {cmd, 32'($urandom)});
    endtask

    task automatic push_end();
        push_item(OSL_KIND_END, random_bits());
    endtask

    // stop sending and let every owed result come out
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all registers plus one unused index while idle
    task automatic apply_setting(input int radius, input int side, input int stop_d,
                                 input int slow_d);
        t_osl_reg reg_idx [4];
        int       value [4];
        reg_idx = '{OSL_REG_RADIUS, OSL_REG_SIDE, OSL_REG_STOP, OSL_REG_SLOW};
        value   = '{radius, side, stop_d, slow_d};
        wait_for_results();
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            if (i < 4) begin
                cfg_index <= reg_idx[i];
                cfg_data  <= 15'(value[i]);
            end else begin
                cfg_index <= 4'($urandom_range(15, OSL_REG_SLOW + 1));
                cfg_data  <= 15'($urandom);
            end
            @(posedge i_clk);
            while (!cfg_ready)
                @(posedge i_clk);
        end
        cfg_valid  <= 1'b0;
        cur_radius = radius;
        cur_side   = side;
        cur_stop   = stop_d;
        cur_slow   = slow_d;
        settings_run++;
    endtask

    // point mostly near the window, some on its edges, some anywhere
    task automatic push_random_point();
        int pick;
        int xs;
        int ys;
        int x;
        int y;
        pick = $urandom_range(99);
        xs   = (cur_radius + 50 > 32767) ? 32767 : cur_radius + 50;
        ys   = (cur_side + 50 > 32767) ? 32767 : cur_side + 50;
        if (pick < 75) begin
            x = $urandom_range(xs, 0);
            y = int'($urandom_range(2 * ys, 0)) - ys;
        end else if (pick < 87) begin
            y = 0;
            case ($urandom_range(5))
                0: x = cur_radius;
                1: begin
                    x = 0;
                    y = ($urandom_range(1) != 0) ? cur_side : -cur_side;
                end
                2: begin
                    x = 30;
                    y = ($urandom_range(1) != 0) ? 40 : -40;
                end
                3: x = $urandom_range(49);
                4: x = cur_stop;
                default: x = cur_slow;
            endcase
        end else begin
            x = $urandom_range(65535);
            y = $urandom_range(65535);
        end
        push_point(x, y);
    endtask

    // one cloud: optional command, a few points, mostly closed by an end marker
    task automatic send_cloud();
        int n_pts;
        if ($urandom_range(99) < 70)
            push_cmd(random_cmd());
        n_pts = ($urandom_range(99) < 8) ? 0 : $urandom_range(12, 1);
        for (int i = 0; i < n_pts; i++) begin
            if ($urandom_range(99) < 4)
                push_item(KIND_UNUSED, random_bits());
            if ($urandom_range(99) < 5)
                push_cmd(random_cmd());
            push_random_point();
        end
        if ($urandom_range(99) < 92)
            push_end();
    endtask

    // main sequence
    initial begin
        int phase_start;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed part on reset register values
        push_end();                          // empty cloud after reset
        push_cmd({16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h0000, 16'h7fff});
        push_point(-1, 0);                   // behind the robot
        push_point(49, 0);                   // inside minimum range
        push_end();                          // nothing kept
        push_point(30, 40);                  // exactly at minimum range
        push_end();                          // stop
        push_point(500, 0);                  // on stop distance
        push_end();
        push_point(1000, 0);                 // on radius and slow distance
        push_point(1001, 0);                 // just outside radius
        push_end();
        push_point(750, 0);                  // slow-down band
        push_end();
        push_point(0, 1001);                 // beyond side limit
        push_point(0, -1000);                // on side limit
        push_end();
        push_cmd({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        push_point(750, 0);                  // slow band, negative speed kept
        push_end();
        push_item(KIND_UNUSED, random_bits());
        push_point(32767, -32768);
        push_point(-32768, 32767);
        push_point(0, 50);
        push_cmd({16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff, 16'h0001});
        push_end();                          // command changed inside the cloud
        push_end();                          // nearest cleared by previous end
        push_point(999, 1);
        push_cmd({80'h0, 16'h7fff});
        push_end();

        // random phases over several register settings and idle patterns
        for (int p = 0; p < N_PHASES; p++) begin
            apply_setting(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            if (p < 2) begin
                src_idle_pct  = 20;
                sink_idle_pct = 45;
            end else if (p < 4) begin
                src_idle_pct  = 45;
                sink_idle_pct = 20;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_cloud();
        end

        wait_for_results();
        $display("sent %0d stream items under reset values and %0d register settings",
                 items_sent, settings_run);
        $display("checked %0d limited commands, %0d slowed and %0d stopped",
                 results, slowed, stopped);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
